/* rtl/stpp_pkg.sv */
// ----------------------------------------------------------------------------
// stpp_pkg
// Shared widths and beat types for the similar-triangle point placement block.
// ----------------------------------------------------------------------------
`default_nettype none

package stpp_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;
  localparam int DenW   = ProdW;
  localparam int NumW   = DiffW + SumW + 1;
  localparam int QuotW  = NumW + 1;
  localparam int DivLat = NumW + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] d_x;
    logic signed [CoordW-1:0] d_y;
    logic signed [CoordW-1:0] e_x;
    logic signed [CoordW-1:0] e_y;
    logic signed [CoordW-1:0] g_x;
    logic signed [CoordW-1:0] g_y;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] f_x;
    logic signed [CoordW-1:0] f_y;
    logic                     mirrored;
    logic                     degenerate;
  } rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [CoordW-1:0] d_x;
    logic signed [CoordW-1:0] d_y;
    logic                     mirrored;
    logic                     degenerate;
  } side_t;

endpackage

`default_nettype wire

/* rtl/stpp_divider.sv */
// ----------------------------------------------------------------------------
// stpp_divider
// Pipelined restoring divider, one quotient bit per stage, truncating signed
// numerator by unsigned denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module stpp_divider (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [stpp_pkg::NumW-1:0]  num,
  input  wire logic        [stpp_pkg::DenW-1:0]  den,
  output logic signed      [stpp_pkg::QuotW-1:0] quo
);

  localparam int NumW  = stpp_pkg::NumW;
  localparam int DenW  = stpp_pkg::DenW;
  localparam int QuotW = stpp_pkg::QuotW;

  logic [NumW-1:0] nq    [0:NumW];
  logic [DenW-1:0] rem   [1:NumW];
  logic [DenW-1:0] dens  [0:NumW];
  logic            neg   [0:NumW];

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]   <= num[NumW-1] ? NumW'(-num) : NumW'(num);
      dens[0] <= den;
      neg[0]  <= num[NumW-1];
    end
  end

  for (genvar i = 0; i < NumW; i++) begin : g_step
    logic [DenW-1:0] rin;
    logic [DenW:0]   trial;
    logic            ge;
    logic [DenW:0]   diff;

    if (i == 0) begin : g_first
      assign rin = '0;
    end else begin : g_rest
      assign rin = rem[i];
    end

    assign trial = {rin, nq[i][NumW-1]};
    assign ge    = trial >= {1'b0, dens[i]};
    assign diff  = trial - {1'b0, dens[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        nq[i+1]   <= {nq[i][NumW-2:0], ge};
        dens[i+1] <= dens[i];
        neg[i+1]  <= neg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[NumW] ? -$signed({1'b0, nq[NumW]}) : $signed({1'b0, nq[NumW]});
    end
  end

endmodule

`default_nettype wire

/* rtl/similar_triangle_point_place.sv */
// ----------------------------------------------------------------------------
// similar_triangle_point_place
// Places F so that triangle DEF is similar to ABC at corner D.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat of six Q12.4 points (A, B, C, D, E, G) under
//   req_valid/req_ready; rsp carries F with the mirrored and degenerate
//   flags under rsp_valid/rsp_ready. One result beat per request beat, in
//   order.
//   Throughput: one beat per cycle while the output is not stalled. The path
//   from req to rsp runs through 62 register stages: six arithmetic stages, a
//   55-register pipelined divider (input register, 53 stages of one quotient
//   bit each, output register) and the output register.
//   Reset clears every valid bit; the pipeline comes up empty and ready.
//   When the receiver holds rsp_ready low with a beat waiting, the whole
//   pipeline freezes and req_ready drops in the same cycle; nothing is lost
//   or repeated, and flow resumes as soon as rsp_ready returns.
//   If A equals B, F is D and degenerate is set.
// ----------------------------------------------------------------------------
`default_nettype none

module similar_triangle_point_place (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire stpp_pkg::req_t   req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output stpp_pkg::rsp_t        rsp
);

  localparam int CoordW = stpp_pkg::CoordW;
  localparam int DiffW  = stpp_pkg::DiffW;
  localparam int ProdW  = stpp_pkg::ProdW;
  localparam int SumW   = stpp_pkg::SumW;
  localparam int DenW   = stpp_pkg::DenW;
  localparam int NumW   = stpp_pkg::NumW;
  localparam int QuotW  = stpp_pkg::QuotW;
  localparam int DivLat = stpp_pkg::DivLat;
  localparam int OutW   = QuotW + 1;

  logic adv;
  assign adv       = !rsp_valid || rsp_ready;
  assign req_ready = adv;

  // stage 1: differences
  logic                     v1;
  logic signed [DiffW-1:0]  abx, aby, acx, acy, dex1, dey1, dgx, dgy;
  logic signed [CoordW-1:0] dx1, dy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      abx  <= DiffW'(req.b_x) - DiffW'(req.a_x);
      aby  <= DiffW'(req.b_y) - DiffW'(req.a_y);
      acx  <= DiffW'(req.c_x) - DiffW'(req.a_x);
      acy  <= DiffW'(req.c_y) - DiffW'(req.a_y);
      dex1 <= DiffW'(req.e_x) - DiffW'(req.d_x);
      dey1 <= DiffW'(req.e_y) - DiffW'(req.d_y);
      dgx  <= DiffW'(req.g_x) - DiffW'(req.d_x);
      dgy  <= DiffW'(req.g_y) - DiffW'(req.d_y);
      dx1  <= req.d_x;
      dy1  <= req.d_y;
    end
  end

  // stage 2: products
  logic                     v2;
  logic signed [ProdW-1:0]  p_xx, p_yy, p_dx, p_dy, p_cx, p_cy, p_sx, p_sy;
  logic signed [DiffW-1:0]  dex2, dey2;
  logic signed [CoordW-1:0] dx2, dy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xx <= abx * abx;
      p_yy <= aby * aby;
      p_dx <= abx * acx;
      p_dy <= aby * acy;
      p_cx <= abx * acy;
      p_cy <= aby * acx;
      p_sx <= dgx * dey1;
      p_sy <= dgy * dex1;
      dex2 <= dex1;
      dey2 <= dey1;
      dx2  <= dx1;
      dy2  <= dy1;
    end
  end

  // stage 3: sums
  logic                     v3;
  logic        [DenW-1:0]   len3;
  logic signed [SumW-1:0]   dot3, crs3, side3;
  logic                     de_nz3;
  logic signed [DiffW-1:0]  dex3, dey3;
  logic signed [CoordW-1:0] dx3, dy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len3   <= DenW'(p_xx) + DenW'(p_yy);
      dot3   <= SumW'(p_dx) + SumW'(p_dy);
      crs3   <= SumW'(p_cx) - SumW'(p_cy);
      side3  <= SumW'(p_sx) - SumW'(p_sy);
      de_nz3 <= (dex2 != '0) || (dey2 != '0);
      dex3   <= dex2;
      dey3   <= dey2;
      dx3    <= dx2;
      dy3    <= dy2;
    end
  end

  // stage 4: orientation
  logic                     v4;
  logic signed [SumW-1:0]   crs_abs;
  logic                     mir_c;
  logic        [DenW-1:0]   len4;
  logic signed [SumW-1:0]   dot4, crs4;
  logic                     mir4, degen4;
  logic signed [DiffW-1:0]  dex4, dey4;
  logic signed [CoordW-1:0] dx4, dy4;

  assign crs_abs = crs3[SumW-1] ? -crs3 : crs3;
  assign mir_c   = (crs_abs != '0) && de_nz3 && side3[SumW-1];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      len4   <= len3;
      dot4   <= dot3;
      crs4   <= mir_c ? -crs_abs : crs_abs;
      mir4   <= mir_c;
      degen4 <= len3 == '0;
      dex4   <= dex3;
      dey4   <= dey3;
      dx4    <= dx3;
      dy4    <= dy3;
    end
  end

  // stage 5: rotation products
  logic                          v5;
  logic signed [DiffW+SumW-1:0]  m1, m2, m3, m4;
  logic        [DenW-1:0]        len5;
  logic                          mir5, degen5;
  logic signed [CoordW-1:0]      dx5, dy5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1     <= dex4 * dot4;
      m2     <= dey4 * crs4;
      m3     <= dey4 * dot4;
      m4     <= dex4 * crs4;
      len5   <= len4;
      mir5   <= mir4;
      degen5 <= degen4;
      dx5    <= dx4;
      dy5    <= dy4;
    end
  end

  // stage 6: numerators
  logic signed [NumW-1:0] nx, ny;
  logic        [DenW-1:0] len6;
  stpp_pkg::side_t        side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      side6.valid <= 1'b0;
    end else if (adv) begin
      side6.valid <= v5;
    end
    if (adv) begin
      nx               <= NumW'(m1) - NumW'(m2);
      ny               <= NumW'(m3) + NumW'(m4);
      len6             <= len5;
      side6.d_x        <= dx5;
      side6.d_y        <= dy5;
      side6.mirrored   <= mir5;
      side6.degenerate <= degen5;
    end
  end

  logic signed [QuotW-1:0] qx, qy;

  stpp_divider u_div_x (
    .clk (clk),
    .en  (adv),
    .num (nx),
    .den (len6),
    .quo (qx)
  );

  stpp_divider u_div_y (
    .clk (clk),
    .en  (adv),
    .num (ny),
    .den (len6),
    .quo (qy)
  );

  stpp_pkg::side_t sd [0:DivLat-1];

  for (genvar i = 0; i < DivLat; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i].valid <= 1'b0;
      end else if (adv) begin
        sd[i].valid <= (i == 0) ? side6.valid : sd[(i == 0) ? 0 : i-1].valid;
      end
      if (adv) begin
        if (i == 0) begin
          sd[i].d_x        <= side6.d_x;
          sd[i].d_y        <= side6.d_y;
          sd[i].mirrored   <= side6.mirrored;
          sd[i].degenerate <= side6.degenerate;
        end else begin
          sd[i].d_x        <= sd[(i == 0) ? 0 : i-1].d_x;
          sd[i].d_y        <= sd[(i == 0) ? 0 : i-1].d_y;
          sd[i].mirrored   <= sd[(i == 0) ? 0 : i-1].mirrored;
          sd[i].degenerate <= sd[(i == 0) ? 0 : i-1].degenerate;
        end
      end
    end
  end

  function automatic logic signed [CoordW-1:0] sat(input logic signed [OutW-1:0] v);
    logic signed [OutW-1:0] hi;
    logic signed [OutW-1:0] lo;
    hi = OutW'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - OutW'(1);
    if (v > hi) return CoordW'(hi);
    else if (v < lo) return CoordW'(lo);
    else return CoordW'(v);
  endfunction

  stpp_pkg::side_t         sl;
  logic signed [OutW-1:0]  fx_sum, fy_sum;

  assign sl     = sd[DivLat-1];
  assign fx_sum = OutW'(qx) + OutW'(sl.d_x);
  assign fy_sum = OutW'(qy) + OutW'(sl.d_y);

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (adv) rsp_valid <= sl.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.f_x        <= sl.degenerate ? sl.d_x : sat(fx_sum);
      rsp.f_y        <= sl.degenerate ? sl.d_y : sat(fy_sum);
      rsp.mirrored   <= sl.degenerate ? 1'b0 : sl.mirrored;
      rsp.degenerate <= sl.degenerate;
    end
  end

endmodule

`default_nettype wire

/* rtl/stpp_checker.sv */
// ----------------------------------------------------------------------------
// stpp_checker
// Port-level checks for the similar-triangle point placement block.
// ----------------------------------------------------------------------------
`default_nettype none

module stpp_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            req_ready,
  input wire logic            rsp_valid,
  input wire logic            rsp_ready,
  input wire stpp_pkg::rsp_t  rsp
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp))
    else $error("rsp beat changed while stalled");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("req accepted while output stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.degenerate |-> !rsp.mirrored)
    else $error("degenerate beat marked mirrored");

endmodule

bind similar_triangle_point_place stpp_checker u_stpp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
